// ===== rtl/lbc_pkg.sv =====
// shared constants and types for the linear block code codec
`timescale 1ns / 1ps

package lbc_pkg;

    localparam int MESSAGE_LENGTH = 5;
    localparam int CODE_LENGTH = 9;
    localparam logic [63:0] PARITY_MATRIX_RESET = 64'd375907;

    localparam int STATUS_WIDTH = 2;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK            = 2'd0,
        STATUS_CORRECTED     = 2'd1,
        STATUS_UNCORRECTABLE = 2'd2
    } t_status;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } t_command;

endpackage

// ===== rtl/lbc_parity.sv =====
// first stage: word selection and parity recomputed from the message bits
`timescale 1ns / 1ps

module lbc_parity #(
    parameter int MESSAGE_LENGTH = lbc_pkg::MESSAGE_LENGTH,
    parameter int CODE_LENGTH = lbc_pkg::CODE_LENGTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  lbc_pkg::t_command           i_command,
    input  logic [MESSAGE_LENGTH-1:0]   i_message,
    input  logic [CODE_LENGTH-1:0]      i_received,
    input  logic [MESSAGE_LENGTH*(CODE_LENGTH-MESSAGE_LENGTH)-1:0] i_matrix,
    output logic                        o_valid,
    input  logic                        i_ready,
    output lbc_pkg::t_command           o_command,
    output logic [CODE_LENGTH-1:0]      o_word,
    output logic [CODE_LENGTH-MESSAGE_LENGTH-1:0] o_parity
);

    localparam int PARITY_LENGTH = CODE_LENGTH - MESSAGE_LENGTH;

    logic                      r_valid;
    lbc_pkg::t_command         r_command;
    logic [CODE_LENGTH-1:0]    r_word;
    logic [PARITY_LENGTH-1:0]  r_parity;
    logic [CODE_LENGTH-1:0]    n_word;
    logic [PARITY_LENGTH-1:0]  n_parity;
    logic [MESSAGE_LENGTH-1:0] msg;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        if (i_command == lbc_pkg::CMD_ENCODE) begin
            msg    = i_message;
            n_word = {i_message, {PARITY_LENGTH{1'b0}}};
        end else begin
            msg    = i_received[CODE_LENGTH-1:PARITY_LENGTH];
            n_word = i_received;
        end
        n_parity = '0;
        for (int r = 0; r < MESSAGE_LENGTH; r++) begin
            if (msg[MESSAGE_LENGTH-1-r]) begin
                n_parity = n_parity ^ i_matrix[(MESSAGE_LENGTH-1-r)*PARITY_LENGTH +: PARITY_LENGTH];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_command <= i_command;
            r_word    <= n_word;
            r_parity  <= n_parity;
        end
    end

    assign o_valid   = r_valid;
    assign o_command = r_command;
    assign o_word    = r_word;
    assign o_parity  = r_parity;

endmodule

// ===== rtl/lbc_syndrome.sv =====
// second stage: syndrome and match against every row of the check matrix
`timescale 1ns / 1ps

module lbc_syndrome #(
    parameter int MESSAGE_LENGTH = lbc_pkg::MESSAGE_LENGTH,
    parameter int CODE_LENGTH = lbc_pkg::CODE_LENGTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  lbc_pkg::t_command           i_command,
    input  logic [CODE_LENGTH-1:0]      i_word,
    input  logic [CODE_LENGTH-MESSAGE_LENGTH-1:0] i_parity,
    input  logic [MESSAGE_LENGTH*(CODE_LENGTH-MESSAGE_LENGTH)-1:0] i_matrix,
    output logic                        o_valid,
    input  logic                        i_ready,
    output lbc_pkg::t_command           o_command,
    output logic [CODE_LENGTH-1:0]      o_word,
    output logic                        o_syndrome_nz,
    output logic [CODE_LENGTH-1:0]      o_match
);

    localparam int PARITY_LENGTH = CODE_LENGTH - MESSAGE_LENGTH;

    logic                     r_valid;
    lbc_pkg::t_command        r_command;
    logic [CODE_LENGTH-1:0]   r_word;
    logic                     r_syndrome_nz;
    logic [CODE_LENGTH-1:0]   r_match;
    logic [CODE_LENGTH-1:0]   n_word;
    logic [CODE_LENGTH-1:0]   n_match;
    logic [PARITY_LENGTH-1:0] syndrome;

    assign o_ready = !r_valid || i_ready;

    // bit i of the match vector stands for position i+1
    always_comb begin
        syndrome = i_parity ^ i_word[PARITY_LENGTH-1:0];
        if (i_command == lbc_pkg::CMD_ENCODE) begin
            n_word = {i_word[CODE_LENGTH-1:PARITY_LENGTH], i_parity};
        end else begin
            n_word = i_word;
        end
        for (int i = 0; i < CODE_LENGTH; i++) begin
            if (i < MESSAGE_LENGTH) begin
                n_match[i] = i_matrix[(MESSAGE_LENGTH-1-i)*PARITY_LENGTH +: PARITY_LENGTH]
                             == syndrome;
            end else begin
                n_match[i] = (PARITY_LENGTH'(1) << (CODE_LENGTH-1-i)) == syndrome;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_command     <= i_command;
            r_word        <= n_word;
            r_syndrome_nz <= |syndrome;
            r_match       <= n_match;
        end
    end

    assign o_valid       = r_valid;
    assign o_command     = r_command;
    assign o_word        = r_word;
    assign o_syndrome_nz = r_syndrome_nz;
    assign o_match       = r_match;

endmodule

// ===== rtl/lbc_correct.sv =====
// third stage: lowest matching position, bit flip and status, output register
`timescale 1ns / 1ps

module lbc_correct #(
    parameter int MESSAGE_LENGTH = lbc_pkg::MESSAGE_LENGTH,
    parameter int CODE_LENGTH = lbc_pkg::CODE_LENGTH,
    parameter int POSITION_WIDTH = $clog2(CODE_LENGTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  lbc_pkg::t_command           i_command,
    input  logic [CODE_LENGTH-1:0]      i_word,
    input  logic                        i_syndrome_nz,
    input  logic [CODE_LENGTH-1:0]      i_match,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [CODE_LENGTH-1:0]      o_codeword,
    output logic [MESSAGE_LENGTH-1:0]   o_message,
    output lbc_pkg::t_status            o_status,
    output logic [POSITION_WIDTH-1:0]   o_position
);

    localparam int PARITY_LENGTH = CODE_LENGTH - MESSAGE_LENGTH;

    logic                      r_valid;
    logic [CODE_LENGTH-1:0]    r_codeword;
    lbc_pkg::t_status          r_status;
    logic [POSITION_WIDTH-1:0] r_position;
    logic [CODE_LENGTH-1:0]    n_codeword;
    lbc_pkg::t_status          n_status;
    logic [POSITION_WIDTH-1:0] n_position;
    logic [CODE_LENGTH-1:0]    flip;
    logic [POSITION_WIDTH-1:0] found_pos;
    logic                      found;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        found     = 1'b0;
        found_pos = '0;
        flip      = '0;
        // scan downwards so the lowest matching position wins
        for (int i = CODE_LENGTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                found     = 1'b1;
                found_pos = POSITION_WIDTH'(i + 1);
                flip      = CODE_LENGTH'(1) << (CODE_LENGTH-1-i);
            end
        end
        n_codeword = i_word;
        n_status   = lbc_pkg::STATUS_OK;
        n_position = '0;
        if (i_command == lbc_pkg::CMD_DECODE && i_syndrome_nz) begin
            if (found) begin
                n_codeword = i_word ^ flip;
                n_status   = lbc_pkg::STATUS_CORRECTED;
                n_position = found_pos;
            end else begin
                n_status   = lbc_pkg::STATUS_UNCORRECTABLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_codeword <= n_codeword;
            r_status   <= n_status;
            r_position <= n_position;
        end
    end

    assign o_valid    = r_valid;
    assign o_codeword = r_codeword;
    assign o_message  = r_codeword[CODE_LENGTH-1:PARITY_LENGTH];
    assign o_status   = r_status;
    assign o_position = r_position;

endmodule

// ===== rtl/linear_block_code_codec.sv =====
// top level of the systematic linear block encoder and single-error decoder
//
//  port group      dir  contents
//  s_axis_*        in   request: tuser command, tdata message_in / received_in
//  m_axis_*        out  result: tdata codeword / message / status / position
//  i_cfg_*         in   parity matrix write, no read-back
//
// one request per cycle sustained while m_axis_tready holds high; the parity,
// syndrome and correction stages are each a register stage
// synchronous active-low reset clears all stage valids and loads the
// default parity matrix
// a stall on m_axis_tready holds the full stages from the output back to the first empty one; empty stages keep filling
`timescale 1ns / 1ps

module linear_block_code_codec #(
    parameter int MESSAGE_LENGTH = lbc_pkg::MESSAGE_LENGTH,
    parameter int CODE_LENGTH = lbc_pkg::CODE_LENGTH,
    parameter int MATRIX_BITS = MESSAGE_LENGTH * (CODE_LENGTH - MESSAGE_LENGTH),
    parameter int POSITION_WIDTH = $clog2(CODE_LENGTH + 1),
    parameter int IN_DATA_WIDTH = ((MESSAGE_LENGTH + CODE_LENGTH + 7) / 8) * 8,
    parameter int OUT_DATA_WIDTH =
        ((CODE_LENGTH + MESSAGE_LENGTH + lbc_pkg::STATUS_WIDTH + POSITION_WIDTH + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // message_in, received_in, zero padding
    input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata,
    // command
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // codeword_out, message_out, status, error_position, zero padding
    output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata,
    input  logic                      i_cfg_we,
    input  logic [MATRIX_BITS-1:0]    i_cfg_wdata
);

    localparam int PARITY_LENGTH = CODE_LENGTH - MESSAGE_LENGTH;
    localparam logic [MATRIX_BITS-1:0] MATRIX_RESET =
        MATRIX_BITS'(lbc_pkg::PARITY_MATRIX_RESET);

    logic [MATRIX_BITS-1:0] r_parity_matrix;

    lbc_pkg::t_command         in_command;
    logic                      s1_valid;
    logic                      s1_ready;
    lbc_pkg::t_command         s1_command;
    logic [CODE_LENGTH-1:0]    s1_word;
    logic [PARITY_LENGTH-1:0]  s1_parity;
    logic                      s2_valid;
    logic                      s2_ready;
    lbc_pkg::t_command         s2_command;
    logic [CODE_LENGTH-1:0]    s2_word;
    logic                      s2_syndrome_nz;
    logic [CODE_LENGTH-1:0]    s2_match;
    logic [CODE_LENGTH-1:0]    out_codeword;
    logic [MESSAGE_LENGTH-1:0] out_message;
    lbc_pkg::t_status          out_status;
    logic [POSITION_WIDTH-1:0] out_position;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity_matrix <= MATRIX_RESET;
        end else if (i_cfg_we) begin
            r_parity_matrix <= i_cfg_wdata;
        end
    end

    assign in_command = lbc_pkg::t_command'(s_axis_tuser);

    lbc_parity #(
        .MESSAGE_LENGTH (MESSAGE_LENGTH),
        .CODE_LENGTH    (CODE_LENGTH)
    ) u_parity (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_command  (in_command),
        .i_message  (s_axis_tdata[MESSAGE_LENGTH-1:0]),
        .i_received (s_axis_tdata[MESSAGE_LENGTH +: CODE_LENGTH]),
        .i_matrix   (r_parity_matrix),
        .o_valid    (s1_valid),
        .i_ready    (s1_ready),
        .o_command  (s1_command),
        .o_word     (s1_word),
        .o_parity   (s1_parity)
    );

    lbc_syndrome #(
        .MESSAGE_LENGTH (MESSAGE_LENGTH),
        .CODE_LENGTH    (CODE_LENGTH)
    ) u_syndrome (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s1_valid),
        .o_ready       (s1_ready),
        .i_command     (s1_command),
        .i_word        (s1_word),
        .i_parity      (s1_parity),
        .i_matrix      (r_parity_matrix),
        .o_valid       (s2_valid),
        .i_ready       (s2_ready),
        .o_command     (s2_command),
        .o_word        (s2_word),
        .o_syndrome_nz (s2_syndrome_nz),
        .o_match       (s2_match)
    );

    lbc_correct #(
        .MESSAGE_LENGTH (MESSAGE_LENGTH),
        .CODE_LENGTH    (CODE_LENGTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_correct (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s2_valid),
        .o_ready       (s2_ready),
        .i_command     (s2_command),
        .i_word        (s2_word),
        .i_syndrome_nz (s2_syndrome_nz),
        .i_match       (s2_match),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_codeword    (out_codeword),
        .o_message     (out_message),
        .o_status      (out_status),
        .o_position    (out_position)
    );

    assign m_axis_tdata = OUT_DATA_WIDTH'({out_position, out_status, out_message, out_codeword});

`ifndef NO_ASSERTIONS
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_corrected_has_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_status == lbc_pkg::STATUS_CORRECTED |-> out_position != '0)
        else $error("corrected result without position");

    a_pos_only_corrected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_status != lbc_pkg::STATUS_CORRECTED |-> out_position == '0)
        else $error("position given without correction");

    a_message_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> out_message == out_codeword[CODE_LENGTH-1:PARITY_LENGTH])
        else $error("message does not match codeword");
`endif

endmodule

// ===== tb/sv/tb_linear_block_code_codec.sv =====
// self-checking stream testbench for the linear block encoder and syndrome decoder
`timescale 1ns / 1ps

module tb_linear_block_code_codec;

    localparam int MLEN = lbc_pkg::MESSAGE_LENGTH;
    localparam int CLEN = lbc_pkg::CODE_LENGTH;
    localparam int PLEN = lbc_pkg::CODE_LENGTH - lbc_pkg::MESSAGE_LENGTH;
    localparam int MBITS = MLEN * PLEN;
    localparam int SW = lbc_pkg::STATUS_WIDTH;
    localparam int POSW = $clog2(CLEN + 1);
    localparam int IN_W = ((MLEN + CLEN + 7) / 8) * 8;
    localparam int OUT_W = ((CLEN + MLEN + SW + POSW + 7) / 8) * 8;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int NUM_PHASES = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;
    localparam logic [MBITS-1:0] MATRIX_DEFAULT = lbc_pkg::PARITY_MATRIX_RESET[MBITS-1:0];

    typedef enum {REQ_ITEM, REQ_CONFIG, REQ_DRAIN, REQ_PHASE} t_request_kind;

    typedef struct {
        t_request_kind     kind;
        lbc_pkg::t_command cmd;
        logic [MLEN-1:0]   msg;
        logic [CLEN-1:0]   rcv;
        logic [MBITS-1:0]  value;
        int                idle;
        int                stall;
    } t_request;

    typedef struct {
        logic [CLEN-1:0]  codeword;
        logic [MLEN-1:0]  message;
        lbc_pkg::t_status status;
        logic [POSW-1:0]  position;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              i_cfg_we;
    logic [MBITS-1:0]  i_cfg_wdata;

    t_request request_q[$];
    t_result  expected_q[$];
    logic [MBITS-1:0] plan_matrix;
    logic [MBITS-1:0] matrix_model;
    int sent_count = 0;
    int taken_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    linear_block_code_codec i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [PLEN-1:0] parity_bits(logic [MBITS-1:0] matrix,
                                                    logic [MLEN-1:0] msg);
        logic [PLEN-1:0] acc;
        acc = '0;
        for (int r = 0; r < MLEN; r++) begin
            if (msg[MLEN-1-r]) acc ^= matrix[(MLEN-1-r)*PLEN +: PLEN];
        end
        return acc;
    endfunction

    function automatic t_result predict_codec(lbc_pkg::t_command cmd, logic [MLEN-1:0] msg,
                                              logic [CLEN-1:0] rcv,
                                              logic [MBITS-1:0] matrix);
        t_result res;
        logic [CLEN-1:0] word;
        logic [PLEN-1:0] syndrome;
        logic [PLEN-1:0] row;
        res.status = lbc_pkg::STATUS_OK;
        res.position = '0;
        if (cmd == lbc_pkg::CMD_ENCODE) begin
            res.codeword = {msg, parity_bits(matrix, msg)};
            res.message = msg;
        end else begin
            word = rcv;
            syndrome = parity_bits(matrix, word[CLEN-1:PLEN]) ^ word[PLEN-1:0];
            if (syndrome != '0) begin
                res.status = lbc_pkg::STATUS_UNCORRECTABLE;
                // first matching row of h-transpose wins
                for (int pos = 1; pos <= CLEN; pos++) begin
                    if (pos <= MLEN) begin
                        row = matrix[(MLEN-pos)*PLEN +: PLEN];
                    end else begin
                        row = PLEN'(1) << (CLEN - pos);
                    end
                    if (res.status == lbc_pkg::STATUS_UNCORRECTABLE && row == syndrome) begin
                        word[CLEN-pos] = ~word[CLEN-pos];
                        res.status = lbc_pkg::STATUS_CORRECTED;
                        res.position = POSW'(pos);
                    end
                end
            end
            res.codeword = word;
            res.message = word[CLEN-1:PLEN];
        end
        return res;
    endfunction

    task automatic push_item(lbc_pkg::t_command cmd, logic [MLEN-1:0] msg,
                             logic [CLEN-1:0] rcv);
        t_request e;
        e = '{kind: REQ_ITEM, cmd: cmd, msg: msg, rcv: rcv, value: '0, idle: 0, stall: 0};
        request_q.push_back(e);
    endtask

    task automatic push_control(t_request_kind kind, logic [MBITS-1:0] value,
                                int idle, int stall);
        t_request e;
        e = '{kind: kind, cmd: lbc_pkg::CMD_ENCODE, msg: '0, rcv: '0, value: value,
              idle: idle, stall: stall};
        request_q.push_back(e);
        if (kind == REQ_CONFIG) plan_matrix = value;
    endtask

    task automatic push_random_item();
        logic [MLEN-1:0] m;
        logic [CLEN-1:0] w;
        int pick;
        m = MLEN'($urandom);
        pick = $urandom_range(9);
        w = {m, parity_bits(plan_matrix, m)};
        if (pick < 2) begin
            w = CLEN'($urandom);
        end else begin
            if (pick >= 4) w[$urandom_range(CLEN-1)] ^= 1'b1;
            if (pick >= 8) w[$urandom_range(CLEN-1)] ^= 1'b1;
        end
        push_item(lbc_pkg::t_command'($urandom_range(1)), MLEN'($urandom), w);
    endtask

    // driver
    always @(negedge i_clk) begin
        t_request e;
        logic valid_next;
        logic cfg_we_next;
        if (i_rst_n) begin
            cfg_we_next = 1'b0;
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
            if (sent_count == taken_count) begin
                valid_next = 1'b0;
                if (request_q.size() != 0) begin
                    e = request_q[0];
                    case (e.kind)
                        REQ_PHASE: begin
                            idle_pct = e.idle;
                            stall_pct = e.stall;
                            void'(request_q.pop_front());
                        end
                        REQ_ITEM: begin
                            if ($urandom_range(99) >= idle_pct) begin
                                s_axis_tdata <= IN_W'({e.rcv, e.msg});
                                s_axis_tuser <= e.cmd;
                                valid_next = 1'b1;
                                sent_count++;
                                void'(request_q.pop_front());
                            end
                        end
                        default: begin
                            // block must be empty before a matrix write or after a drain
                            if (expected_q.size() == 0) begin
                                if (e.kind == REQ_CONFIG) begin
                                    cfg_we_next = 1'b1;
                                    i_cfg_wdata <= e.value;
                                end
                                void'(request_q.pop_front());
                            end
                        end
                    endcase
                end
                s_axis_tvalid <= valid_next;
            end
            i_cfg_we <= cfg_we_next;
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_result exp_res;
        t_result act;
        logic in_req;
        logic out_req;
        if (i_rst_n) begin
            in_req = s_axis_tvalid && s_axis_tready;
            out_req = m_axis_tvalid && m_axis_tready;
            if (i_cfg_we) matrix_model = i_cfg_wdata;
            if (in_req) begin
                expected_q.push_back(predict_codec(lbc_pkg::t_command'(s_axis_tuser),
                                                   s_axis_tdata[MLEN-1:0],
                                                   s_axis_tdata[MLEN +: CLEN],
                                                   matrix_model));
                taken_count++;
            end
            if (out_req) begin
                act.codeword = m_axis_tdata[CLEN-1:0];
                act.message = m_axis_tdata[CLEN +: MLEN];
                act.status = lbc_pkg::t_status'(m_axis_tdata[CLEN+MLEN +: SW]);
                act.position = m_axis_tdata[CLEN+MLEN+SW +: POSW];
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: cw %h msg %h status %0d pos %0d",
                                 act.codeword, act.message, act.status, act.position);
                end else begin
                    exp_res = expected_q.pop_front();
                    if (act.codeword !== exp_res.codeword || act.message !== exp_res.message ||
                        act.status !== exp_res.status || act.position !== exp_res.position) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected cw %h msg %h status %0d pos %0d, %s",
                                     exp_res.codeword, exp_res.message, exp_res.status,
                                     exp_res.position,
                                     $sformatf("got cw %h msg %h status %0d pos %0d",
                                               act.codeword, act.message, act.status,
                                               act.position));
                    end
                end
            end
            if (in_req || out_req) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("linear_block_code_codec test failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [CLEN-1:0] cw;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        plan_matrix = MATRIX_DEFAULT;
        matrix_model = MATRIX_DEFAULT;

        // directed: field extremes, every single-bit error, uncorrectable syndrome
        push_control(REQ_PHASE, '0, 0, 0);
        push_item(lbc_pkg::CMD_ENCODE, '0, '0);
        push_item(lbc_pkg::CMD_ENCODE, '1, '1);
        push_item(lbc_pkg::CMD_ENCODE, 5'b10101, '0);
        push_item(lbc_pkg::CMD_ENCODE, 5'b01010, '1);
        cw = {5'b10110, parity_bits(plan_matrix, 5'b10110)};
        push_item(lbc_pkg::CMD_DECODE, '0, cw);
        for (int p = 1; p <= CLEN; p++)
            push_item(lbc_pkg::CMD_DECODE, '1, cw ^ (CLEN'(1) << (CLEN - p)));
        push_item(lbc_pkg::CMD_DECODE, '0, CLEN'(7));
        push_item(lbc_pkg::CMD_DECODE, '0, '1);
        push_item(lbc_pkg::CMD_DECODE, '1, '0);

        // zero first row and duplicated rows equal to a parity unit vector
        push_control(REQ_CONFIG, 20'h08835, 0, 0);
        cw = {5'b00000, parity_bits(plan_matrix, 5'b00000)};
        push_item(lbc_pkg::CMD_DECODE, '0, cw ^ (CLEN'(1) << (CLEN - 1)));
        push_item(lbc_pkg::CMD_DECODE, '0, cw ^ (CLEN'(1) << (CLEN - 2)));
        push_item(lbc_pkg::CMD_DECODE, '0, cw ^ (CLEN'(1) << (CLEN - 6)));
        push_item(lbc_pkg::CMD_ENCODE, '1, '0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: push_control(REQ_CONFIG, MATRIX_DEFAULT, 0, 0);
                1: push_control(REQ_CONFIG, '1, 0, 0);
                2: push_control(REQ_CONFIG, '0, 0, 0);
                5: push_control(REQ_CONFIG, 20'h08835, 0, 0);
                7: push_control(REQ_CONFIG, MATRIX_DEFAULT, 0, 0);
                default: push_control(REQ_CONFIG, MBITS'($urandom), 0, 0);
            endcase
            case (ph % 4)
                0: push_control(REQ_PHASE, '0, 0, 0);
                1: push_control(REQ_PHASE, '0, 69, 0);
                2: push_control(REQ_PHASE, '0, 0, 69);
                default: push_control(REQ_PHASE, '0, 14, 14);
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == ITEMS_PER_PHASE / 2) push_control(REQ_DRAIN, '0, 0, 0);
                push_random_item();
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || sent_count != taken_count || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_q.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("linear_block_code_codec test passed");
        end else begin
            $display("linear_block_code_codec test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lbc_pkg.sv
rtl/lbc_parity.sv
rtl/lbc_syndrome.sv
rtl/lbc_correct.sv
rtl/linear_block_code_codec.sv
tb/sv/tb_linear_block_code_codec.sv
